FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the sector sequencer.
// Depends on nothing; included by modules that assert.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_RST(label, clk, prop, msg)
`endif
`endif

FILE: hw/rtl/ata_seq_pkg.sv
// Package for the ATA PIO sector sequencer: item types, phase codes, constants.
// Depends on nothing.
`default_nettype none
package ata_seq_pkg;
  localparam int SectorWordsDefault = 256;
  localparam logic [19:0] PollLimitReset = 20'd1000000;

  localparam logic [2:0] CMD_LOAD  = 3'd0;
  localparam logic [2:0] CMD_READ  = 3'd1;
  localparam logic [2:0] CMD_WRITE = 3'd2;
  localparam logic [2:0] CMD_RET   = 3'd3;
  localparam logic [2:0] CMD_PROBE = 3'd4;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_ABSENT  = 3'd1;
  localparam logic [2:0] ST_BUSY    = 3'd2;
  localparam logic [2:0] ST_NODRQ   = 3'd3;
  localparam logic [2:0] ST_BUSYDAT = 3'd4;
  localparam logic [2:0] ST_FLUSH   = 3'd5;

  localparam logic [1:0] OP_PROBE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;

  localparam logic [9:0] PORT_DATA = 10'h1F0;
  localparam logic [9:0] PORT_SC   = 10'h1F2;
  localparam logic [9:0] PORT_L0   = 10'h1F3;
  localparam logic [9:0] PORT_L1   = 10'h1F4;
  localparam logic [9:0] PORT_L2   = 10'h1F5;
  localparam logic [9:0] PORT_DRV  = 10'h1F6;
  localparam logic [9:0] PORT_CMD  = 10'h1F7;
  localparam logic [9:0] PORT_CTRL = 10'h3F6;

  localparam logic [7:0] ATA_IDENT_DEV = 8'hEC;
  localparam logic [7:0] ATA_READ      = 8'h20;
  localparam logic [7:0] ATA_WRITE     = 8'h30;
  localparam logic [7:0] ATA_FLUSH     = 8'hE7;
  localparam logic [7:0] DRV_LBA       = 8'hE0;
  localparam logic [7:0] DRV_IDENT     = 8'hA0;
  localparam logic [7:0] CTRL_NIEN     = 8'h02;
  localparam logic [7:0] STAT_FLOAT    = 8'hFF;

  typedef enum logic [5:0] {
    PH_IDLE, I_CTRL, I_DRV, I_DLY1, I_SC, I_L0, I_L1, I_L2, I_CMD, I_DLY2,
    I_ST, I_WNB, I_CHK1, I_CHK2, I_WDRQ, I_DATA,
    T_WNB, T_DRV, T_SC, T_L0, T_L1, T_L2, T_CMD, T_WDRQ, T_RDATA, T_WDATA,
    T_WNB2, T_FLUSH, T_WNB3
  } phase_t;

  typedef struct packed {
    logic [2:0]  command;
    logic [27:0] lba;
    logic [15:0] data;
  } in_item_t;

  typedef struct packed {
    logic        bus_valid;
    logic        bus_write;
    logic        bus_wide;
    logic [9:0]  bus_port;
    logic [15:0] bus_data;
    logic        word_valid;
    logic [15:0] word_out;
    logic        done_res;
    logic [2:0]  status;
    logic        present;
    logic [31:0] sector_count;
  } out_item_t;

  // state visible to the access encoder
  typedef struct packed {
    phase_t      phase;
    logic [1:0]  op;
    logic [27:0] lba;
  } seq_view_t;
endpackage
`default_nettype wire

FILE: hw/rtl/ata_pio_sector_sequencer.sv
// ATA PIO LBA28 sector sequencer.
// Channels: in (valid/ready, in_item_t) carries buffer loads, requests and
// bus returns; out (valid/ready, out_item_t) carries exactly one result per
// accepted item: a port access, a sector word, and/or the done status.
// APB port: register 0 at address 0 is poll_limit (20 bits).
// Result is registered: valid in the cycle after input acceptance.
// Throughput: one item per cycle unless the receiver stalls; the phase
// register and the output register are the only stages. The write
// buffer is a 1-write/1-read memory; its read port is addressed ahead so the
// next word is ready in the data phase; back-to-back load and write are fine.
// Reset clears all control state and sets poll_limit to 1000000; the write
// buffer holds unknown data until loaded.
// When the receiver stalls, the output register holds; a new item is taken
// only if the output register is empty or is being drained the same cycle.
// Depends on ata_seq_pkg, ata_seq_access, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module ata_pio_sector_sequencer #(
  parameter int SectorWords = ata_seq_pkg::SectorWordsDefault
) (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        in_valid,
  output logic                       in_ready,
  input  wire ata_seq_pkg::in_item_t in_item,
  output logic                       out_valid,
  input  wire                        out_ready,
  output ata_seq_pkg::out_item_t     out_item,
  input  wire                        psel,
  input  wire                        penable,
  input  wire                        pwrite,
  input  wire [1:0]                  paddr,
  input  wire [31:0]                 pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import ata_seq_pkg::*;
  localparam int IdxW = $clog2(SectorWords);
  localparam logic [8:0] LastWord = 9'(SectorWords);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(SectorWords - 1);

  logic [19:0] poll_limit;
  logic probed, drive_present;
  logic [31:0] capacity;
  logic [IdxW-1:0] fill_index, fill_index_next;
  phase_t phase, phase_next;
  logic [8:0] word_counter, word_counter_next;
  logic [19:0] poll_counter, poll_counter_next;
  logic [27:0] pending_lba, pending_lba_next;
  logic [1:0] pending_op, pending_op_next;
  logic probed_next, present_next;
  logic [31:0] capacity_next;
  logic [15:0] wbuf [SectorWords];
  logic [15:0] wbuf_rd;
  logic [IdxW-1:0] rd_addr;
  logic take;
  out_item_t res;
  logic [2:0] cmd;
  logic [7:0] st;
  logic acc_write, acc_wide;
  logic [9:0] acc_port;
  logic [15:0] acc_data;
  seq_view_t view;

  assign pready = 1'b1;
  assign prdata = {12'h000, poll_limit};
  assign in_ready = !out_valid || out_ready;
  assign take = in_valid && in_ready;
  assign cmd = in_item.command;
  assign st = in_item.data[7:0];

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      poll_limit <= PollLimitReset;
    end else if (psel && penable && pwrite && paddr == 2'd0) begin
      poll_limit <= pwdata[19:0];
    end
  end

  // write buffer memory; read address runs one word ahead of the data phase
  always_ff @(posedge clk) begin
    if (take && phase == PH_IDLE && cmd == CMD_LOAD) begin
      wbuf[fill_index] <= in_item.data;
    end
    wbuf_rd <= wbuf[rd_addr];
  end

  // sequencer next-state logic
  always_comb begin
    logic [19:0] pc1;
    logic ok, fail;
    pc1 = poll_counter + 20'd1;
    ok = 1'b0;
    fail = 1'b0;
    phase_next = phase;
    word_counter_next = word_counter;
    poll_counter_next = poll_counter;
    pending_lba_next = pending_lba;
    pending_op_next = pending_op;
    fill_index_next = fill_index;
    probed_next = probed;
    present_next = drive_present;
    capacity_next = capacity;
    res = '0;
    if (phase == PH_IDLE) begin
      if (cmd == CMD_LOAD) begin
        fill_index_next = (fill_index == LastIdx) ? '0 : fill_index + 1'b1;
      end else if (cmd == CMD_READ || cmd == CMD_WRITE || cmd == CMD_PROBE) begin
        pending_op_next = (cmd == CMD_PROBE) ? OP_PROBE : cmd[1:0];
        pending_lba_next = in_item.lba;
        if (cmd == CMD_WRITE) fill_index_next = '0;
        if (!probed) begin
          probed_next = 1'b1; phase_next = I_CTRL;
        end else if (!drive_present) begin
          res.done_res = 1'b1; res.status = ST_ABSENT;
        end else if (cmd == CMD_PROBE) begin
          res.done_res = 1'b1; res.status = ST_OK;
        end else begin
          phase_next = T_WNB;
        end
      end
    end else if (cmd == CMD_RET) begin
      // poll evaluation for the polling phases
      if (phase == I_WDRQ || phase == T_WDRQ) begin
        if ((st & 8'h21) != 8'h00) fail = 1'b1;
        else if (!st[7] && st[3]) ok = 1'b1;
      end else begin
        if (st == STAT_FLOAT) fail = 1'b1;
        else if (!st[7]) ok = 1'b1;
      end
      if (!ok && !fail) begin
        poll_counter_next = pc1;
        if (pc1 >= poll_limit) fail = 1'b1;
      end
      case (phase)
        I_CTRL: phase_next = I_DRV;
        I_DRV: phase_next = I_DLY1;
        I_DLY1, I_DLY2: begin
          word_counter_next = word_counter + 9'd1;
          if (word_counter_next >= 9'd4) phase_next = (phase == I_DLY1) ? I_SC : I_ST;
        end
        I_SC: phase_next = I_L0;
        I_L0: phase_next = I_L1;
        I_L1: phase_next = I_L2;
        I_L2: phase_next = I_CMD;
        I_CMD: phase_next = I_DLY2;
        I_ST: begin
          if (st == 8'h00 || st == STAT_FLOAT) begin
            phase_next = PH_IDLE; res.done_res = 1'b1; res.status = ST_ABSENT;
          end else phase_next = I_WNB;
        end
        I_WNB, I_WDRQ, T_WNB, T_WDRQ, T_WNB2, T_WNB3: begin
          if (ok) begin
            case (phase)
              I_WNB: phase_next = I_CHK1;
              I_WDRQ: phase_next = I_DATA;
              T_WNB: phase_next = T_DRV;
              T_WDRQ: phase_next = (pending_op == OP_WRITE) ? T_WDATA : T_RDATA;
              T_WNB2: phase_next = T_FLUSH;
              default: begin
                phase_next = PH_IDLE; res.done_res = 1'b1; res.status = ST_OK;
              end
            endcase
          end else if (fail) begin
            phase_next = PH_IDLE;
            res.done_res = 1'b1;
            case (phase)
              T_WNB: res.status = ST_BUSY;
              T_WDRQ: res.status = ST_NODRQ;
              T_WNB2: res.status = ST_BUSYDAT;
              T_WNB3: res.status = ST_FLUSH;
              default: res.status = ST_ABSENT;
            endcase
          end
        end
        I_CHK1, I_CHK2: begin
          if (st != 8'h00) begin
            phase_next = PH_IDLE; res.done_res = 1'b1; res.status = ST_ABSENT;
          end else phase_next = (phase == I_CHK1) ? I_CHK2 : I_WDRQ;
        end
        I_DATA: begin
          if (word_counter == 9'd60) capacity_next[15:0] = in_item.data;
          if (word_counter == 9'd61) capacity_next[31:16] = in_item.data;
          word_counter_next = word_counter + 9'd1;
          if (word_counter_next >= LastWord) begin
            present_next = 1'b1;
            if (pending_op == OP_PROBE) begin
              phase_next = PH_IDLE; res.done_res = 1'b1; res.status = ST_OK;
            end else phase_next = T_WNB;
          end
        end
        T_DRV: phase_next = T_SC;
        T_SC: phase_next = T_L0;
        T_L0: phase_next = T_L1;
        T_L1: phase_next = T_L2;
        T_L2: phase_next = T_CMD;
        T_CMD: phase_next = T_WDRQ;
        T_RDATA: begin
          res.word_valid = 1'b1;
          res.word_out = in_item.data;
          word_counter_next = word_counter + 9'd1;
          if (word_counter_next >= LastWord) begin
            phase_next = PH_IDLE; res.done_res = 1'b1; res.status = ST_OK;
          end
        end
        T_WDATA: begin
          word_counter_next = word_counter + 9'd1;
          if (word_counter_next >= LastWord) phase_next = T_WNB2;
        end
        T_FLUSH: phase_next = T_WNB3;
        default: phase_next = PH_IDLE;
      endcase
    end
    if (phase_next != phase) begin
      word_counter_next = '0;
      poll_counter_next = '0;
    end
    res.present = present_next;
    res.sector_count = present_next ? capacity_next : 32'd0;
  end

  // buffer read address: word to send in the coming data phase
  always_comb begin
    if (take && phase_next == T_WDATA) rd_addr = word_counter_next[IdxW-1:0];
    else rd_addr = word_counter[IdxW-1:0];
  end

  assign view.phase = phase_next;
  assign view.op = pending_op_next;
  assign view.lba = pending_lba_next;

  ata_seq_access u_access (
    .view      (view),
    .wbuf_word (16'h0000),
    .acc_write (acc_write),
    .acc_wide  (acc_wide),
    .acc_port  (acc_port),
    .acc_data  (acc_data)
  );

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      probed <= 1'b0;
      drive_present <= 1'b0;
      capacity <= '0;
      fill_index <= '0;
      word_counter <= '0;
      poll_counter <= '0;
      pending_lba <= '0;
      pending_op <= OP_PROBE;
    end else if (take) begin
      phase <= phase_next;
      probed <= probed_next;
      drive_present <= present_next;
      capacity <= capacity_next;
      fill_index <= fill_index_next;
      word_counter <= word_counter_next;
      poll_counter <= poll_counter_next;
      pending_lba <= pending_lba_next;
      pending_op <= pending_op_next;
    end
  end

  // full result with the port access fields filled in
  out_item_t res_bus;
  always_comb begin
    res_bus = res;
    res_bus.bus_valid = (phase_next != PH_IDLE);
    res_bus.bus_write = (phase_next != PH_IDLE) && acc_write;
    res_bus.bus_wide = (phase_next != PH_IDLE) && acc_wide;
    res_bus.bus_port = (phase_next != PH_IDLE) ? acc_port : 10'd0;
    res_bus.bus_data = (phase_next != PH_IDLE) ? acc_data : 16'd0;
  end

  // result register; write data word is merged from the buffer read port
  out_item_t res_q;
  logic wdata_q;
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (take) begin
      res_q <= res_bus;
      wdata_q <= (phase_next == T_WDATA);
    end
  end

  // hold the buffer word while stalled
  logic [15:0] wword_hold;
  logic hold_ok;
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_ok <= 1'b0;
    end else if (take) begin
      hold_ok <= 1'b0;
    end else if (out_valid && !hold_ok) begin
      hold_ok <= 1'b1;
    end
    if (!hold_ok) wword_hold <= wbuf_rd;
  end

  always_comb begin
    out_item = res_q;
    if (wdata_q) out_item.bus_data = hold_ok ? wword_hold : wbuf_rd;
  end

  `ASSERT_CLK(a_idle_no_bus, clk, rst,
    out_valid && !out_item.bus_valid |-> phase == PH_IDLE,
    "bus access missing while a request runs")
  `ASSERT_CLK(a_done_idle, clk, rst,
    out_valid && out_item.done_res |-> phase == PH_IDLE,
    "done reported with request still running")
  `ASSERT_CLK(a_word_read, clk, rst,
    out_valid && out_item.word_valid |-> !out_item.bus_valid || phase == T_RDATA,
    "sector word outside a read")
  `ASSERT_CLK(a_absent_count, clk, rst,
    out_valid && !out_item.present |-> out_item.sector_count == 32'd0,
    "capacity shown for absent drive")
endmodule
`default_nettype wire

FILE: hw/rtl/ata_seq_access.sv
// Port access encoder: maps the next phase to one bus access.
// Depends on ata_seq_pkg.
`default_nettype none
module ata_seq_access (
  input  wire ata_seq_pkg::seq_view_t view,
  input  wire [15:0]                  wbuf_word,
  output logic                        acc_write,
  output logic                        acc_wide,
  output logic [9:0]                  acc_port,
  output logic [15:0]                 acc_data
);
  import ata_seq_pkg::*;

  always_comb begin
    acc_port = PORT_CMD;
    acc_data = '0;
    acc_write = 1'b1;
    acc_wide = 1'b0;
    case (view.phase)
      I_CTRL: begin acc_port = PORT_CTRL; acc_data = {8'h00, CTRL_NIEN}; end
      I_DRV: begin acc_port = PORT_DRV; acc_data = {8'h00, DRV_IDENT}; end
      I_DLY1, I_DLY2: begin acc_port = PORT_CTRL; acc_write = 1'b0; end
      I_SC: acc_port = PORT_SC;
      I_L0: acc_port = PORT_L0;
      I_L1: acc_port = PORT_L1;
      I_L2: acc_port = PORT_L2;
      I_CMD: acc_data = {8'h00, ATA_IDENT_DEV};
      I_CHK1: begin acc_port = PORT_L1; acc_write = 1'b0; end
      I_CHK2: begin acc_port = PORT_L2; acc_write = 1'b0; end
      I_DATA, T_RDATA: begin
        acc_port = PORT_DATA; acc_write = 1'b0; acc_wide = 1'b1;
      end
      T_DRV: begin
        acc_port = PORT_DRV;
        acc_data = {8'h00, DRV_LBA | {4'h0, view.lba[27:24]}};
      end
      T_SC: begin acc_port = PORT_SC; acc_data = 16'd1; end
      T_L0: begin acc_port = PORT_L0; acc_data = {8'h00, view.lba[7:0]}; end
      T_L1: begin acc_port = PORT_L1; acc_data = {8'h00, view.lba[15:8]}; end
      T_L2: begin acc_port = PORT_L2; acc_data = {8'h00, view.lba[23:16]}; end
      T_CMD: acc_data = {8'h00, (view.op == OP_WRITE) ? ATA_WRITE : ATA_READ};
      T_WDATA: begin acc_port = PORT_DATA; acc_wide = 1'b1; acc_data = wbuf_word; end
      T_FLUSH: acc_data = {8'h00, ATA_FLUSH};
      default: acc_write = 1'b0;
    endcase
  end
endmodule
`default_nettype wire

FILE: sim/ata_seq_checker.sv
// Checker for the ATA PIO sector sequencer: it follows the item channels and
// the APB port, predicts each result and compares it field by field.
// Depends on ata_seq_pkg.
`timescale 1ns / 1ps
module ata_seq_checker
  import ata_seq_pkg::*;
(
  input  wire        clk,
  input  wire        rst,
  input  wire        in_valid,
  input  wire        in_ready,
  input  in_item_t   in_item,
  input  wire        out_valid,
  input  wire        out_ready,
  input  out_item_t  out_item,
  input  wire        psel,
  input  wire        penable,
  input  wire        pwrite,
  input  wire        pready,
  input  wire [1:0]  paddr,
  input  wire [31:0] pwdata,
  output int         errors,
  output int         pending
);
  localparam int SW = SectorWordsDefault;
  localparam logic [1:0] REG_POLL_LIMIT = 2'd0;

  // shadow of the sequencer
  phase_t      ph;
  logic        probed_q, present_q;
  logic [31:0] capacity_q;
  logic [15:0] wbuf [256];
  logic [7:0]  fill_idx;
  logic [8:0]  wcnt;
  logic [19:0] pcnt, limit_q;
  logic [27:0] req_lba;
  logic [1:0]  req_op;
  logic        done_f;
  logic [2:0]  status_f;

  out_item_t result_q[$];

  assign pending = result_q.size();

  function automatic void go(phase_t p);
    ph = p;
    wcnt = '0;
    pcnt = '0;
  endfunction

  function automatic void finish_req(logic [2:0] code);
    go(PH_IDLE);
    done_f = 1'b1;
    status_f = code;
  endfunction

  // 0 keep polling, 1 satisfied, 2 give up
  function automatic int poll(bit want_drq, logic [7:0] s);
    if (want_drq) begin
      if ((s & 8'h21) != 0) return 2;
      if (!s[7] && s[3]) return 1;
    end else begin
      if (s == STAT_FLOAT) return 2;
      if (!s[7]) return 1;
    end
    pcnt = pcnt + 1'b1;
    if (pcnt >= limit_q) return 2;
    return 0;
  endfunction

  function automatic out_item_t sequence_step(in_item_t it);
    out_item_t o;
    logic [7:0] s;
    int r;
    o = '0;
    s = it.data[7:0];
    done_f = 1'b0;
    status_f = ST_OK;
    if (ph == PH_IDLE) begin
      if (it.command == CMD_LOAD) begin
        wbuf[fill_idx] = it.data;
        fill_idx = fill_idx + 1'b1;
      end else if (it.command == CMD_READ || it.command == CMD_WRITE ||
                   it.command == CMD_PROBE) begin
        req_op = (it.command == CMD_PROBE) ? OP_PROBE : it.command[1:0];
        req_lba = it.lba;
        if (it.command == CMD_WRITE) fill_idx = '0;
        if (!probed_q) begin
          probed_q = 1'b1;
          go(I_CTRL);
        end else if (!present_q) finish_req(ST_ABSENT);
        else if (req_op == OP_PROBE) finish_req(ST_OK);
        else go(T_WNB);
      end
    end else if (it.command == CMD_RET) begin
      case (ph)
        I_CTRL: go(I_DRV);
        I_DRV:  go(I_DLY1);
        I_DLY1: begin
          wcnt = wcnt + 1'b1;
          if (wcnt >= 4) go(I_SC);
        end
        I_SC:   go(I_L0);
        I_L0:   go(I_L1);
        I_L1:   go(I_L2);
        I_L2:   go(I_CMD);
        I_CMD:  go(I_DLY2);
        I_DLY2: begin
          wcnt = wcnt + 1'b1;
          if (wcnt >= 4) go(I_ST);
        end
        I_ST: begin
          if (s == 8'h00 || s == STAT_FLOAT) finish_req(ST_ABSENT);
          else go(I_WNB);
        end
        I_WNB: begin
          r = poll(1'b0, s);
          if (r == 1) go(I_CHK1);
          else if (r == 2) finish_req(ST_ABSENT);
        end
        I_CHK1: if (s != 0) finish_req(ST_ABSENT); else go(I_CHK2);
        I_CHK2: if (s != 0) finish_req(ST_ABSENT); else go(I_WDRQ);
        I_WDRQ: begin
          r = poll(1'b1, s);
          if (r == 1) go(I_DATA);
          else if (r == 2) finish_req(ST_ABSENT);
        end
        I_DATA: begin
          if (wcnt == 60) capacity_q[15:0] = it.data;
          if (wcnt == 61) capacity_q[31:16] = it.data;
          wcnt = wcnt + 1'b1;
          if (wcnt >= SW) begin
            present_q = 1'b1;
            if (req_op == OP_PROBE) finish_req(ST_OK);
            else go(T_WNB);
          end
        end
        T_WNB: begin
          r = poll(1'b0, s);
          if (r == 1) go(T_DRV);
          else if (r == 2) finish_req(ST_BUSY);
        end
        T_DRV:  go(T_SC);
        T_SC:   go(T_L0);
        T_L0:   go(T_L1);
        T_L1:   go(T_L2);
        T_L2:   go(T_CMD);
        T_CMD:  go(T_WDRQ);
        T_WDRQ: begin
          r = poll(1'b1, s);
          if (r == 1) go(req_op == OP_WRITE ? T_WDATA : T_RDATA);
          else if (r == 2) finish_req(ST_NODRQ);
        end
        T_RDATA: begin
          o.word_valid = 1'b1;
          o.word_out = it.data;
          wcnt = wcnt + 1'b1;
          if (wcnt >= SW) finish_req(ST_OK);
        end
        T_WDATA: begin
          wcnt = wcnt + 1'b1;
          if (wcnt >= SW) go(T_WNB2);
        end
        T_WNB2: begin
          r = poll(1'b0, s);
          if (r == 1) go(T_FLUSH);
          else if (r == 2) finish_req(ST_BUSYDAT);
        end
        T_FLUSH: go(T_WNB3);
        T_WNB3: begin
          r = poll(1'b0, s);
          if (r == 1) finish_req(ST_OK);
          else if (r == 2) finish_req(ST_FLUSH);
        end
        default: go(PH_IDLE);
      endcase
    end

    // port access for the phase now entered
    if (ph != PH_IDLE) begin
      o.bus_valid = 1'b1;
      o.bus_write = 1'b1;
      o.bus_port = PORT_CMD;
      case (ph)
        I_CTRL: begin o.bus_port = PORT_CTRL; o.bus_data = {8'h00, CTRL_NIEN}; end
        I_DRV:  begin o.bus_port = PORT_DRV; o.bus_data = {8'h00, DRV_IDENT}; end
        I_DLY1, I_DLY2: begin o.bus_port = PORT_CTRL; o.bus_write = 1'b0; end
        I_SC:   o.bus_port = PORT_SC;
        I_L0:   o.bus_port = PORT_L0;
        I_L1:   o.bus_port = PORT_L1;
        I_L2:   o.bus_port = PORT_L2;
        I_CMD:  o.bus_data = {8'h00, ATA_IDENT_DEV};
        I_CHK1: begin o.bus_port = PORT_L1; o.bus_write = 1'b0; end
        I_CHK2: begin o.bus_port = PORT_L2; o.bus_write = 1'b0; end
        I_DATA, T_RDATA: begin
          o.bus_port = PORT_DATA;
          o.bus_write = 1'b0;
          o.bus_wide = 1'b1;
        end
        T_DRV: begin
          o.bus_port = PORT_DRV;
          o.bus_data = {8'h00, DRV_LBA | {4'h0, req_lba[27:24]}};
        end
        T_SC:  begin o.bus_port = PORT_SC; o.bus_data = 16'd1; end
        T_L0:  begin o.bus_port = PORT_L0; o.bus_data = {8'h00, req_lba[7:0]}; end
        T_L1:  begin o.bus_port = PORT_L1; o.bus_data = {8'h00, req_lba[15:8]}; end
        T_L2:  begin o.bus_port = PORT_L2; o.bus_data = {8'h00, req_lba[23:16]}; end
        T_CMD: o.bus_data = {8'h00, (req_op == OP_WRITE) ? ATA_WRITE : ATA_READ};
        T_WDATA: begin
          o.bus_port = PORT_DATA;
          o.bus_wide = 1'b1;
          o.bus_data = wbuf[wcnt[7:0]];
        end
        T_FLUSH: o.bus_data = {8'h00, ATA_FLUSH};
        default: o.bus_write = 1'b0;
      endcase
    end
    o.done_res = done_f;
    o.status = status_f;
    o.present = present_q;
    o.sector_count = present_q ? capacity_q : 32'd0;
    return o;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
    errors++;
  endtask

  task automatic compare(out_item_t got, out_item_t want);
    if (got.bus_valid !== want.bus_valid) report("bus_valid", got.bus_valid, want.bus_valid);
    if (got.bus_write !== want.bus_write) report("bus_write", got.bus_write, want.bus_write);
    if (got.bus_wide !== want.bus_wide) report("bus_wide", got.bus_wide, want.bus_wide);
    if (got.bus_port !== want.bus_port) report("bus_port", got.bus_port, want.bus_port);
    if (got.bus_data !== want.bus_data) report("bus_data", got.bus_data, want.bus_data);
    if (got.word_valid !== want.word_valid) report("word_valid", got.word_valid, want.word_valid);
    if (got.word_out !== want.word_out) report("word_out", got.word_out, want.word_out);
    if (got.done_res !== want.done_res) report("done_res", got.done_res, want.done_res);
    if (got.status !== want.status) report("status", got.status, want.status);
    if (got.present !== want.present) report("present", got.present, want.present);
    if (got.sector_count !== want.sector_count)
      report("sector_count", got.sector_count, want.sector_count);
  endtask

  initial errors = 0;

  always @(posedge clk) begin
    if (rst) begin
      go(PH_IDLE);
      probed_q = 1'b0;
      present_q = 1'b0;
      capacity_q = '0;
      fill_idx = '0;
      req_lba = '0;
      req_op = OP_PROBE;
      limit_q = PollLimitReset;
      result_q.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == REG_POLL_LIMIT)
        limit_q = pwdata[19:0];
      // results leave before this edge's item is predicted
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) report("unexpected result", out_item.bus_port, 0);
        else compare(out_item, result_q.pop_front());
      end
      if (in_valid && in_ready) result_q.push_back(sequence_step(in_item));
    end
  end
endmodule

FILE: sim/ata_pio_sector_sequencer_tb.sv
// Testbench top for the ATA PIO sector sequencer: clock, reset, item and APB
// stimulus with a scripted drive model; the verdict comes from ata_seq_checker.
// Depends on ata_seq_pkg, ata_seq_checker and the sequencer RTL.
`timescale 1ns / 1ps
module ata_pio_sector_sequencer_tb;
  import ata_seq_pkg::*;

  localparam int SW = SectorWordsDefault;
  localparam logic [1:0] REG_POLL_LIMIT = 2'd0;
  localparam int STALL_LIMIT = 3000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_item;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          errors, pending;

  in_item_t    sector_items[$];
  int          snd_idle = 0, rcv_idle = 0;
  int          hold_left = 0;
  int          item_total = 0;
  int          cur_limit = 1000000;
  int          quiet_cycles = 0;

  ata_pio_sector_sequencer uut (
    .clk, .rst, .in_valid, .in_ready, .in_item, .out_valid, .out_ready, .out_item,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  ata_seq_checker chk (
    .clk, .rst, .in_valid, .in_ready, .in_item, .out_valid, .out_ready, .out_item,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata, .errors, .pending
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // sender: offers the next item when the slot is free
  always @(posedge clk) begin
    if (!rst && (!in_valid || in_ready)) begin
      if (sector_items.size() != 0 && $urandom_range(99) >= snd_idle) begin
        in_item <= sector_items.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver, with a long hold-off when asked
  always @(posedge clk) begin
    if (hold_left > 0) hold_left <= hold_left - 1;
    out_ready <= !rst && hold_left <= 1 && $urandom_range(99) >= rcv_idle;
  end

  // watchdog on cycles with no item moving
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic [7:0] rb();
    return 8'($urandom);
  endfunction

  // mostly random words, with the extremes now and then
  function automatic logic [15:0] rw();
    int k;
    k = $urandom_range(9);
    if (k == 0) return 16'h0000;
    if (k == 1) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  function automatic logic [27:0] rlba();
    return 28'($urandom);
  endfunction

  task automatic push(logic [2:0] cmd, logic [27:0] lba, logic [15:0] data);
    in_item_t it;
    it.command = cmd;
    it.lba = lba;
    it.data = data;
    sector_items.push_back(it);
    item_total++;
  endtask

  task automatic ret(logic [15:0] data);
    push(CMD_RET, rlba(), data);
  endtask

  // item the block ignores while a request runs
  task automatic noise();
    logic [2:0] c;
    if ($urandom_range(15) == 0) begin
      c = 3'($urandom_range(6));
      if (c >= CMD_RET) c = c + 1'b1;
      push(c, rlba(), rw());
    end
  endtask

  // 0 clean, 1 bad status, 2 poll limit run out (small limits only)
  function automatic int pick_fault(int pct);
    if ($urandom_range(99) < pct) return $urandom_range(1, 2);
    return 0;
  endfunction

  task automatic poll_seq(bit want_drq, int fault, output bit ok);
    int n, nmax;
    logic [7:0] r;
    nmax = (cur_limit > 4) ? 3 : cur_limit - 1;
    n = $urandom_range(nmax);
    if (fault == 2 && cur_limit <= 4) n = cur_limit;
    repeat (n) begin
      r = rb();
      ret({rb(), want_drq ? (8'h80 | (r & 8'h5E)) : (8'h80 | (r & 8'h7E))});
    end
    r = rb();
    if (fault == 2 && cur_limit <= 4) begin
      // the busy polls above already end the wait
    end else if (fault != 0) begin
      ret({rb(), want_drq ? ((r & 8'hDE) | ($urandom_range(1) ? 8'h01 : 8'h20))
                          : STAT_FLOAT});
    end else begin
      ret({rb(), want_drq ? ((r & 8'h56) | 8'h08) : (r & 8'h7F)});
    end
    ok = (fault == 0);
  endtask

  // IDENTIFY run that finds a drive
  task automatic identify();
    bit ok;
    push(CMD_PROBE, rlba(), rw());
    repeat (15) begin noise(); ret(rw()); end
    ret({rb(), (rb() & 8'h3F) | 8'h40});
    poll_seq(1'b0, 0, ok);
    ret({rb(), 8'h00});
    ret({rb(), 8'h00});
    poll_seq(1'b1, 0, ok);
    repeat (SW) begin noise(); ret(rw()); end
  endtask

  task automatic transfer(logic [2:0] req, logic [27:0] lba, int pct);
    bit ok;
    push(req, lba, rw());
    noise();
    poll_seq(1'b0, pick_fault(pct), ok);
    if (!ok) return;
    repeat (6) begin noise(); ret(rw()); end
    poll_seq(1'b1, pick_fault(pct), ok);
    if (!ok) return;
    repeat (SW) begin noise(); ret(rw()); end
    if (req == CMD_WRITE) begin
      poll_seq(1'b0, pick_fault(pct), ok);
      if (!ok) return;
      ret(rw());
      poll_seq(1'b0, pick_fault(pct), ok);
    end
  endtask

  task automatic load_words(int n);
    repeat (n) push(CMD_LOAD, rlba(), rw());
  endtask

  task automatic drain();
    do @(posedge clk); while (sector_items.size() != 0 || in_valid || pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_poll_limit(int v);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= REG_POLL_LIMIT;
    pwdata <= 32'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cur_limit = v;
  endtask

  initial begin
    int k, n;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: idle oddities, identify, then a probe of the known drive
    snd_idle = 22;
    rcv_idle = 77;
    set_poll_limit(1000000);
    for (k = 5; k <= 7; k++) push(3'(k), 28'hFFFFFFF, 16'hFFFF);
    push(CMD_RET, 28'h0, 16'h0000);
    push(CMD_LOAD, 28'h0, 16'h0000);
    push(CMD_LOAD, 28'hFFFFFFF, 16'hFFFF);
    identify();
    push(CMD_PROBE, 28'h0, 16'h0);
    drain();

    // full buffer, clean write at the top address, then writes with faults
    // at limit one
    snd_idle = 77;
    rcv_idle = 22;
    set_poll_limit(1);
    load_words(SW);
    transfer(CMD_WRITE, 28'hFFFFFFF, 0);
    repeat (2) transfer(CMD_WRITE, rlba(), 40);
    drain();

    // random mix, starting with a long receiver hold-off
    snd_idle = 0;
    rcv_idle = 0;
    set_poll_limit(3);
    hold_left = 300;
    n = 0;
    while (item_total < 1150 || n < 2) begin
      k = $urandom_range(99);
      if (k < 45) transfer(CMD_READ, rlba(), 20);
      else if (k < 80) begin
        load_words($urandom_range(5));
        transfer(CMD_WRITE, rlba(), 20);
      end else if (k < 90) push(CMD_PROBE, rlba(), rw());
      else push($urandom_range(1) ? CMD_RET : 3'($urandom_range(5, 7)), rlba(), rw());
      n++;
    end
    drain();
    repeat (10) @(posedge clk);
    if (errors == 0 && pending == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
